[hw/rtl/sbd_pkg.sv]
// Shared types and constants for the six-bit character to byte decoder.
// No dependencies; used by every other file of the block.
package sbd_pkg;

	localparam int unsigned CharW   = 8;
	localparam int unsigned ValueW  = 16;
	localparam int unsigned PayW    = 6;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [CharW-1:0] ChCr = 8'h0D;
	localparam logic [CharW-1:0] ChLf = 8'h0A;
	// top two bits of a data character
	localparam logic [1:0] DataTag = 2'b01;

	typedef enum logic [1:0] {
		ST_DATA = 2'd0,
		ST_END  = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_WORD_MODE  = 2'd0,
		REG_SWAP_BYTES = 2'd1,
		REG_END_MARKER = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic             word_mode;
		logic             swap_bytes;
		logic [CharW-1:0] end_marker;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [ValueW-1:0] value;
		status_t           status;
	} result_t;

endpackage

[hw/rtl/sbd_if.sv]
// Valid/ready channel interfaces for the decoder: character input and result output.
// Depends on sbd_pkg for field widths.
interface sbd_char_if;
	logic                      valid;
	logic                      ready;
	logic [sbd_pkg::CharW-1:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink   (input valid, input char_in, output ready);
endinterface

interface sbd_res_if;
	logic                       valid;
	logic                       ready;
	logic [sbd_pkg::ValueW-1:0] value;
	logic [1:0]                 status;

	modport source (output valid, output value, output status, input ready);
	modport sink   (input valid, input value, input status, output ready);
endinterface

[hw/rtl/sbd_cfg_regs.sv]
// Configuration registers of the decoder, written through a plain write port.
// Depends on sbd_pkg.
module sbd_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [sbd_pkg::CfgIdxW-1:0]   index,
	input  logic [sbd_pkg::CharW-1:0]     data,
	output sbd_pkg::cfg_t                 cfg
);

	sbd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (we) begin
			unique case (index)
				sbd_pkg::REG_WORD_MODE:  cfg_q.word_mode  <= data[0];
				sbd_pkg::REG_SWAP_BYTES: cfg_q.swap_bytes <= data[0];
				sbd_pkg::REG_END_MARKER: cfg_q.end_marker <= data;
				default: ; // unused index, ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/sbd_decode_core.sv]
// Decode state and combinational decode of one character into a result.
// Depends on sbd_pkg.
module sbd_decode_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [sbd_pkg::CharW-1:0] char_in,
	input  sbd_pkg::cfg_t             cfg,
	output sbd_pkg::result_t          res
);

	logic [1:0]                 phase_q;
	logic                       byte_held_q;
	logic [sbd_pkg::PayW-1:0]   left_q;
	logic [sbd_pkg::CharW-1:0]  held_q;

	logic                       is_skip;
	logic                       is_data;
	logic [sbd_pkg::PayW-1:0]   pay;
	logic [sbd_pkg::CharW-1:0]  b;
	logic                       have_byte;
	logic [1:0]                 phase_d;
	logic                       byte_held_d;
	logic                       load_held;

	assign is_skip = (char_in == sbd_pkg::ChCr) || (char_in == sbd_pkg::ChLf);
	assign is_data = (char_in[7:6] == sbd_pkg::DataTag);
	assign pay     = char_in[sbd_pkg::PayW-1:0];

	// regroup: MSBs first, carrying leftover bits of the previous char
	always_comb begin
		unique case (phase_q)
			2'd0: b = '0;
			2'd1: b = {left_q, pay[5:4]};
			2'd2: b = {left_q[3:0], pay[5:2]};
			2'd3: b = {left_q[1:0], pay};
		endcase
	end

	assign have_byte = is_data && (phase_q != 2'd0);

	always_comb begin
		res         = '0;
		res.status  = sbd_pkg::ST_DATA;
		phase_d     = phase_q;
		byte_held_d = byte_held_q;
		load_held   = 1'b0;
		priority if (is_skip) begin
			// CR/LF: nothing
		end else if (!is_data) begin
			phase_d     = 2'd0;
			byte_held_d = 1'b0;
			res.valid   = 1'b1;
			res.status  = (char_in == cfg.end_marker) ? sbd_pkg::ST_END : sbd_pkg::ST_BAD;
		end else if (!have_byte) begin
			phase_d = 2'd1;
		end else begin
			phase_d = phase_q + 2'd1;
			if (!cfg.word_mode) begin
				byte_held_d = 1'b0;
				res.valid   = 1'b1;
				res.value   = {8'h00, b};
			end else if (!byte_held_q) begin
				byte_held_d = 1'b1;
				load_held   = 1'b1;
			end else begin
				byte_held_d = 1'b0;
				res.valid   = 1'b1;
				res.value   = cfg.swap_bytes ? {held_q, b} : {b, held_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			byte_held_q <= 1'b0;
		end else if (en) begin
			phase_q     <= phase_d;
			byte_held_q <= byte_held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en && is_data && !is_skip) begin
			left_q <= pay;
		end
		if (en && load_held) begin
			held_q <= b;
		end
	end

endmodule

[hw/rtl/six_bit_char_to_byte_decoder.sv]
// Six-bit printable character to byte decoder, top level.
// An accepted character goes through the input register, then is decoded into
// the result register. Throughput: one character per cycle while the result
// slot is free, that is while the downstream keeps up.
// Reset (arst_n, async, active low) clears both stages, the decode state and
// the config registers (byte mode, no swap, end marker 0x00).
// Depends on sbd_pkg, sbd_if, sbd_cfg_regs, sbd_decode_core.
module six_bit_char_to_byte_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	sbd_char_if.sink                    char_ch,
	sbd_res_if.source                   res_ch,
	input  logic                        cfg_we,
	input  logic [sbd_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [sbd_pkg::CharW-1:0]   cfg_data
);

	sbd_pkg::cfg_t    cfg;
	sbd_pkg::result_t res;

	// stage 1: registered input character
	logic                      valid_s1;
	logic [sbd_pkg::CharW-1:0] char_s1;

	// result register
	logic                       out_valid_q;
	logic [sbd_pkg::ValueW-1:0] out_value_q;
	sbd_pkg::status_t           out_status_q;

	logic out_free;
	logic adv_s1;

	// The result slot is free when empty or being taken this cycle; stage 1
	// moves on whenever the slot is free, so a full pipe still takes a character
	// per cycle while the downstream keeps up.
	assign out_free = !out_valid_q || res_ch.ready;
	assign adv_s1   = valid_s1 && out_free;
	assign char_ch.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ch.ready) begin
			valid_s1 <= char_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ch.ready && char_ch.valid) begin
			char_s1 <= char_ch.char_in;
		end
	end

	sbd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// decode state only advances when the stage-1 char is consumed
	sbd_decode_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv_s1),
		.char_in (char_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && res.valid) begin
			out_value_q  <= res.value;
			out_status_q <= res.status;
		end
	end

	assign res_ch.valid  = out_valid_q;
	assign res_ch.value  = out_value_q;
	assign res_ch.status = out_status_q;

endmodule
